[design/lcas_pkg.sv]
`timescale 1ns / 1ps

package lcas_pkg;

    // Width of each size register on the configuration port.
    localparam int unsigned CFG_W = 10;

    // Register index codes on the configuration port.
    typedef enum logic [1:0] {
        CFG_COLS = 2'd0,
        CFG_ROWS = 2'd1
    } t_cfg_idx;

    // Depth of the queue between the front and back parts.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Bit of the 3x3 neighborhood that holds the center cell.
    localparam int unsigned CENTER_BIT = 4;

    // Neighbor counts of the B3/S23 rule.
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    // One interior cell as classified by the front part.
    // Bits 0..2: column two back, bits 3..5: column one back,
    // bits 6..8: current column, each as top, middle, bottom.
    typedef struct packed {
        logic [8:0] cells;
        logic       last;
    } t_nbhd;

    // Queue status seen by the top level.
    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_q_status;

endpackage

[design/lcas_ram.sv]
`timescale 1ns / 1ps

module lcas_ram #(
    parameter int unsigned WIDTH = 2,
    parameter int unsigned DEPTH = 514
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/lcas_front.sv]
`timescale 1ns / 1ps

module lcas_front #(
    parameter int unsigned COLS_LIMIT = 512,
    parameter int unsigned MAX_ROWS   = 512
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_restart,
    input  logic [lcas_pkg::CFG_W-1:0] i_cols,
    input  logic [lcas_pkg::CFG_W-1:0] i_rows,
    input  logic                    i_cell_valid,
    input  logic                    i_cell_alive,
    output logic                    o_cell_stall,
    input  logic                    i_q_full,
    output logic                    o_push,
    output lcas_pkg::t_nbhd         o_nbhd
);

    import lcas_pkg::*;

    localparam int unsigned STORE_DEPTH = COLS_LIMIT + 2;
    localparam int unsigned COL_W       = $clog2(COLS_LIMIT + 2);
    localparam int unsigned ROW_W       = $clog2(MAX_ROWS + 2);

    logic [31:0]      cols_eff;
    logic [31:0]      rows_eff;
    logic [COL_W-1:0] col_last;
    logic [ROW_W-1:0] row_last;

    logic [COL_W-1:0] r_col;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] r_row;
    logic [ROW_W-1:0] n_row;
    logic [5:0]       r_win;
    logic [5:0]       n_win;

    logic             accept;
    logic [1:0]       store_rd;
    logic [1:0]       store_wr;
    logic [2:0]       column;

    // Effective tile size: the register clamped to one up to the maximum.
    always_comb begin
        cols_eff = 32'(i_cols);
        if (cols_eff < 32'd1) begin
            cols_eff = 32'd1;
        end else if (cols_eff > 32'(COLS_LIMIT)) begin
            cols_eff = 32'(COLS_LIMIT);
        end
        rows_eff = 32'(i_rows);
        if (rows_eff < 32'd1) begin
            rows_eff = 32'd1;
        end else if (rows_eff > 32'(MAX_ROWS)) begin
            rows_eff = 32'(MAX_ROWS);
        end
    end

    // Index of the last padded column and row.
    assign col_last = COL_W'(cols_eff + 32'd1);
    assign row_last = ROW_W'(rows_eff + 32'd1);

    assign o_cell_stall = i_q_full;
    assign accept       = i_cell_valid && !i_q_full;

    // Both line stores share one address, so they sit in one two-bit wide RAM:
    // bit 1 holds the row two above, bit 0 the row one above.
    assign column   = {i_cell_alive, store_rd[0], store_rd[1]};
    assign store_wr = {store_rd[0], i_cell_alive};

    // The read address runs one step ahead so the registered read data
    // belongs to the column of the next item.
    lcas_ram #(
        .WIDTH(2),
        .DEPTH(STORE_DEPTH)
    ) u_line_store (
        .i_clk    (i_clk),
        .i_we     (accept),
        .i_wr_addr(r_col),
        .i_wr_data(store_wr),
        .i_rd_addr(n_col),
        .o_rd_data(store_rd)
    );

    // Position counters and window update.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_win = r_win;
        if (i_restart) begin
            n_col = '0;
            n_row = '0;
            n_win = '0;
        end else if (accept) begin
            n_win = {column, r_win[5:3]};
            if (r_col == col_last) begin
                n_col = '0;
                n_row = (r_row == row_last) ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_win <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_win <= n_win;
        end
    end

    // Only interior cells with a full neighborhood go to the back part.
    assign o_push       = accept && (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2));
    assign o_nbhd.cells = {column, r_win};
    assign o_nbhd.last  = (r_row == row_last) && (r_col == col_last);

endmodule

[design/lcas_queue.sv]
`timescale 1ns / 1ps

module lcas_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  lcas_pkg::t_nbhd       i_data,
    input  logic                  i_pop,
    output lcas_pkg::t_nbhd       o_data,
    output lcas_pkg::t_q_status   o_status
);

    import lcas_pkg::*;

    t_nbhd             r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    assign o_data         = r_slot[r_rd_ptr];
    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_status.count = r_count;

endmodule

[design/lcas_back.sv]
`timescale 1ns / 1ps

module lcas_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  lcas_pkg::t_nbhd i_nbhd,
    output logic            o_pop,
    output logic            o_res_valid,
    input  logic            i_res_stall,
    output logic            o_next_alive,
    output logic            o_tile_last
);

    import lcas_pkg::*;

    logic       r_valid;
    logic       r_next_alive;
    logic       r_tile_last;
    logic       load;
    logic [3:0] count;
    logic       center;
    logic       next_alive;

    // Count the eight neighbors around the center cell.
    always_comb begin
        count = '0;
        for (int i = 0; i < 9; i++) begin
            if (i != CENTER_BIT) begin
                count = count + 4'(i_nbhd.cells[i]);
            end
        end
    end

    // B3/S23 rule.
    assign center     = i_nbhd.cells[CENTER_BIT];
    assign next_alive = (count == BIRTH_COUNT) || (center && (count == SURVIVE_COUNT));

    // The output register takes a new result whenever it is free or being taken.
    assign load  = !r_valid || !i_res_stall;
    assign o_pop = load && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_next_alive <= next_alive;
            r_tile_last  <= i_nbhd.last;
        end
    end

    assign o_res_valid  = r_valid;
    assign o_next_alive = r_next_alive;
    assign o_tile_last  = r_tile_last;

endmodule

[design/life_cell_automaton_stencil.sv]
`timescale 1ns / 1ps

// Channel    Valid          Stall          Payload
// cell in    i_cell_valid   o_cell_stall   i_cell_alive
// result     o_res_valid    i_res_stall    o_next_alive, o_tile_last
// config     i_cfg_we       (none)         i_cfg_index, i_cfg_data
//
// One cell item is taken every cycle while the queue is not full; a result for the item
// that completes its 3x3 neighborhood passes through the queue entry and then the
// output register. The line store read runs one column ahead and adds no delay.
// Reset (synchronous, active low) sets both sizes to 320 and starts a new tile;
// line store contents are not cleared and need no clearing pass.
// A stalled result backs up into a four-entry queue; cells stall only when it is full.

module life_cell_automaton_stencil #(
    parameter int unsigned COLS_LIMIT = 512,
    parameter int unsigned MAX_ROWS   = 512
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [lcas_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                       i_cell_valid,
    output logic                       o_cell_stall,
    input  logic                       i_cell_alive,
    output logic                       o_res_valid,
    input  logic                       i_res_stall,
    output logic                       o_next_alive,
    output logic                       o_tile_last
);

    import lcas_pkg::*;

    logic [CFG_W-1:0] r_cols;
    logic [CFG_W-1:0] r_rows;
    logic             restart;
    logic             push;
    logic             pop;
    t_nbhd            push_nbhd;
    t_nbhd            head_nbhd;
    t_q_status        q_status;

    // Size registers; a write to either restarts the tile.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= CFG_W'(320);
            r_rows <= CFG_W'(320);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_COLS: r_cols <= i_cfg_data;
                CFG_ROWS: r_rows <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign restart = i_cfg_we &&
        ((t_cfg_idx'(i_cfg_index) == CFG_COLS) || (t_cfg_idx'(i_cfg_index) == CFG_ROWS));

    lcas_front #(
        .COLS_LIMIT(COLS_LIMIT),
        .MAX_ROWS  (MAX_ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (restart),
        .i_cols      (r_cols),
        .i_rows      (r_rows),
        .i_cell_valid(i_cell_valid),
        .i_cell_alive(i_cell_alive),
        .o_cell_stall(o_cell_stall),
        .i_q_full    (q_status.full),
        .o_push      (push),
        .o_nbhd      (push_nbhd)
    );

    lcas_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_nbhd),
        .i_pop   (pop),
        .o_data  (head_nbhd),
        .o_status(q_status)
    );

    lcas_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_status.empty),
        .i_nbhd      (head_nbhd),
        .o_pop       (pop),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .o_next_alive(o_next_alive),
        .o_tile_last (o_tile_last)
    );

    // The queue never takes an item while full.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_status.full)
        else $error("queue push while full");

    // The back part never pops an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.empty |-> !pop)
        else $error("queue pop while empty");

    // A new result appears only after the queue held an entry.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res_valid) |-> $past(!q_status.empty))
        else $error("result without queued neighborhood");

    // Input stall is raised whenever the queue is full.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_status.count == QCNT_W'(QUEUE_DEPTH)) |-> o_cell_stall)
        else $error("cell taken while queue full");

endmodule

[tb/life_generation_checker.sv]
`timescale 1ns / 1ps

// Watches the configuration port and both channels of the Life stencil.
// It keeps its own copy of the line stores, window and tile position,
// works out the next generation of each interior cell as cells are taken,
// and compares every result taken from the block against the oldest one.
module life_generation_checker #(
    parameter int unsigned COLS_LIMIT = 512,
    parameter int unsigned MAX_ROWS   = 512
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [lcas_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                       i_cell_valid,
    input  logic                       i_cell_stall,
    input  logic                       i_cell_alive,
    input  logic                       i_res_valid,
    input  logic                       i_res_stall,
    input  logic                       i_next_alive,
    input  logic                       i_tile_last,
    output int                         o_pending,
    output int                         o_fail_count
);

    import lcas_pkg::*;

    localparam int unsigned      STORE_DEPTH       = COLS_LIMIT + 2;
    localparam logic [CFG_W-1:0] RESET_SIZE        = 10'd320;
    localparam logic [3:0]       BIRTH_NEIGHBORS   = 4'd3;
    localparam logic [3:0]       SURVIVE_NEIGHBORS = 4'd2;
    localparam int unsigned      MID_OF_LAST_COL   = 4;

    typedef struct packed {
        logic next_alive;
        logic tile_last;
    } t_next_gen;

    t_next_gen              next_gen_q[$];
    logic [CFG_W-1:0]       cols_reg = RESET_SIZE;
    logic [CFG_W-1:0]       rows_reg = RESET_SIZE;
    logic [STORE_DEPTH-1:0] upper_row = '0;
    logic [STORE_DEPTH-1:0] middle_row = '0;
    logic [5:0]             window = '0;
    logic [9:0]             col_pos = '0;
    logic [9:0]             row_pos = '0;
    int                     fail_total = 0;

    // A size of zero acts as one; sizes above the maximum are clamped.
    function automatic int unsigned effective_size(input logic [CFG_W-1:0] value,
                                                   input int unsigned limit);
        if (value == '0) return 1;
        if (value > limit) return limit;
        return 32'(value);
    endfunction

    // Takes one padded-tile cell and queues the next state of the interior
    // cell whose neighborhood it completes.
    task automatic predict_cell(input logic bottom);
        int unsigned width;
        int unsigned height;
        logic        top_cell;
        logic        mid_cell;
        logic [2:0]  column;
        logic [3:0]  neighbors;
        t_next_gen   gen;
        width = effective_size(cols_reg, COLS_LIMIT) + 2;
        height = effective_size(rows_reg, MAX_ROWS) + 2;
        top_cell = upper_row[col_pos];
        mid_cell = middle_row[col_pos];
        upper_row[col_pos] = mid_cell;
        middle_row[col_pos] = bottom;
        column = {bottom, mid_cell, top_cell};

        if (row_pos >= 2 && col_pos >= 2) begin
            neighbors = window[0] + window[1] + window[2] + window[3] + window[5]
                      + top_cell + mid_cell + bottom;
            gen.next_alive = (neighbors == BIRTH_NEIGHBORS)
                          || (window[MID_OF_LAST_COL] && neighbors == SURVIVE_NEIGHBORS);
            gen.tile_last = (row_pos == height - 1) && (col_pos == width - 1);
            next_gen_q.push_back(gen);
        end

        window = {column, window[5:3]};

        // Step through the padded tile, wrapping at its end.
        if (col_pos + 1 >= width) begin
            col_pos = '0;
            if (row_pos + 1 >= height) begin
                row_pos = '0;
            end else begin
                row_pos = row_pos + 1'b1;
            end
        end else begin
            col_pos = col_pos + 1'b1;
        end
    endtask

    // A size write restarts the tile; the line stores keep their contents.
    task automatic restart_tile();
        window = '0;
        col_pos = '0;
        row_pos = '0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cols_reg = RESET_SIZE;
            rows_reg = RESET_SIZE;
            restart_tile();
            next_gen_q.delete();
        end else begin
            // Compare each result taken with the oldest expected one.
            if (i_res_valid && !i_res_stall) begin
                if (next_gen_q.size() == 0) begin
                    $error("result with nothing expected: next_alive %0b, tile_last %0b",
                           i_next_alive, i_tile_last);
                    fail_total++;
                end else begin
                    if (i_next_alive !== next_gen_q[0].next_alive) begin
                        $error("next_alive mismatch: expected %0b, actual %0b",
                               next_gen_q[0].next_alive, i_next_alive);
                        fail_total++;
                    end
                    if (i_tile_last !== next_gen_q[0].tile_last) begin
                        $error("tile_last mismatch: expected %0b, actual %0b",
                               next_gen_q[0].tile_last, i_tile_last);
                        fail_total++;
                    end
                    void'(next_gen_q.pop_front());
                end
            end

            // Configuration writes, then the cell taken at this edge.
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_COLS) begin
                    cols_reg = i_cfg_data;
                    restart_tile();
                end else if (i_cfg_index == CFG_ROWS) begin
                    rows_reg = i_cfg_data;
                    restart_tile();
                end
            end
            if (i_cell_valid && !i_cell_stall) begin
                predict_cell(i_cell_alive);
            end
        end
        o_pending <= next_gen_q.size();
        o_fail_count <= fail_total;
    end

endmodule

[tb/life_cell_automaton_stencil_tb.sv]
`timescale 1ns / 1ps

module life_cell_automaton_stencil_tb;
    import lcas_pkg::*;

    localparam int unsigned      COLS_LIMIT    = 512;
    localparam int unsigned      MAX_ROWS      = 512;
    localparam int               RESET_CYCLES  = 3;
    localparam int               SETTLE_CYCLES = 6;
    localparam int               DRAIN_CYCLES  = 16;
    localparam int               HOLD_CYCLES   = 300;
    localparam int               LIMIT_CYCLES  = 400000;
    localparam int               RANDOM_CELLS  = 600;
    localparam int               WIDE_CELLS    = 120;
    localparam int               TALL_CELLS    = 3 * 40;
    localparam logic [1:0]       SPARE_IDX     = 2'd3;
    localparam logic [CFG_W-1:0] SIZE_ALL_ONES = '1;

    // Padded 3x3 tiles, bit i is raster cell i, bit 4 is the interior cell.
    localparam logic [8:0] BIRTH_TILE   = 9'b000_000_111;
    localparam logic [8:0] SURVIVE_TILE = 9'b100_010_001;
    localparam logic [8:0] CROWDED_TILE = 9'b111_111_111;

    logic             i_clk;
    logic             i_rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [1:0]       cfg_index = CFG_COLS;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             cell_valid = 1'b0;
    logic             cell_stall;
    logic             cell_alive = 1'b0;
    logic             res_valid;
    logic             res_stall = 1'b0;
    logic             next_alive;
    logic             tile_last;
    int               pending;
    int               fail_count;
    int               cycle_count = 0;
    int               snd_idle_pct = 0;
    int               rcv_idle_pct = 0;
    int               random_cells = 0;
    bit               hold_go = 1'b0;

    life_cell_automaton_stencil #(
        .COLS_LIMIT(COLS_LIMIT),
        .MAX_ROWS  (MAX_ROWS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_cell_valid(cell_valid),
        .o_cell_stall(cell_stall),
        .i_cell_alive(cell_alive),
        .o_res_valid (res_valid),
        .i_res_stall (res_stall),
        .o_next_alive(next_alive),
        .o_tile_last (tile_last)
    );

    life_generation_checker #(
        .COLS_LIMIT(COLS_LIMIT),
        .MAX_ROWS  (MAX_ROWS)
    ) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_cell_valid(cell_valid),
        .i_cell_stall(cell_stall),
        .i_cell_alive(cell_alive),
        .i_res_valid (res_valid),
        .i_res_stall (res_stall),
        .i_next_alive(next_alive),
        .i_tile_last (tile_last),
        .o_pending   (pending),
        .o_fail_count(fail_count)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Give up if the run hangs.
    initial begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("Simulation FAILED");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            res_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    // Offers one cell item, with random gaps first, and waits until it is taken.
    task automatic send_cell(input logic alive);
        while ($urandom_range(99) < snd_idle_pct) begin
            cell_valid <= 1'b0;
            @(posedge i_clk);
        end
        cell_valid <= 1'b1;
        cell_alive <= alive;
        @(posedge i_clk);
        while (cell_stall) @(posedge i_clk);
    endtask

    task automatic send_pattern(input logic [8:0] pattern);
        for (int i = 0; i < 9; i++) begin
            send_cell(pattern[i]);
        end
    endtask

    // Random cells, live with the given chance in percent.
    task automatic send_cells(input int count, input int density);
        for (int i = 0; i < count; i++) begin
            send_cell($urandom_range(99) < density);
        end
    endtask

    // Lets every expected result come out and the pipeline go quiet.
    task automatic wait_idle();
        cell_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows);
        wait_idle();
        write_reg(CFG_COLS, cols);
        write_reg(CFG_ROWS, rows);
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input int snd_pct, input int rcv_pct);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
    endtask

    function automatic int random_density();
        case ($urandom_range(3))
            0: return 10;
            1: return 35;
            2: return 50;
            default: return 80;
        endcase
    endfunction

    // Small random tiles, mostly whole, sometimes cut short by a new size.
    task automatic random_tiles(input int target);
        int cols;
        int rows;
        int tile_cells;
        int tiles;
        int count;
        while (random_cells < target) begin
            cols = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 16);
            rows = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 10);
            configure(CFG_W'(cols), CFG_W'(rows));
            tile_cells = ((cols == 0 ? 1 : cols) + 2) * ((rows == 0 ? 1 : rows) + 2);
            tiles = $urandom_range(1, 3);
            for (int t = 0; t < tiles; t++) begin
                if ($urandom_range(7) == 0) begin
                    count = $urandom_range(1, tile_cells - 1);
                    send_cells(count, random_density());
                    random_cells += count;
                    break;
                end
                send_cells(tile_cells, random_density());
                random_cells += tile_cells;
            end
        end
    endtask

    // Stimulus and verdict.
    initial begin
        set_idling(24, 46);
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero sizes act as one; a write to an unused index changes nothing.
        wait_idle();
        write_reg(CFG_COLS, '0);
        write_reg(CFG_ROWS, '0);
        write_reg(SPARE_IDX, SIZE_ALL_ONES);
        cfg_we <= 1'b0;
        send_pattern(BIRTH_TILE);
        send_pattern(SURVIVE_TILE);
        send_pattern(CROWDED_TILE);
        random_tiles(RANDOM_CELLS / 4);

        // Largest sizes, each with the other size at its smallest; only the
        // opening part of each tile is sent.
        set_idling(46, 24);
        configure(SIZE_ALL_ONES, CFG_W'(1));
        send_cells(WIDE_CELLS, 50);
        configure(CFG_W'(1), SIZE_ALL_ONES);
        send_cells(TALL_CELLS, 50);
        random_cells += WIDE_CELLS + TALL_CELLS;
        random_tiles(2 * RANDOM_CELLS / 3);

        // Long hold-off on results while cells keep coming.
        set_idling(0, 0);
        configure(CFG_W'(12), CFG_W'(8));
        hold_go = 1'b1;
        send_cells(14 * 10, random_density());
        random_cells += 14 * 10;
        random_tiles(RANDOM_CELLS);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[files.f]
design/lcas_pkg.sv
design/lcas_ram.sv
design/lcas_front.sv
design/lcas_queue.sv
design/lcas_back.sv
design/life_cell_automaton_stencil.sv
tb/life_generation_checker.sv
tb/life_cell_automaton_stencil_tb.sv
